### hdl/cbrtf_pkg.sv
// Package for the Threefry-2x64 20-round counter-based random generator.
// Holds the beat types, the per-lane pipeline word, the round constants and
// the round and key-injection functions. Depends on nothing.
package cbrtf_pkg;

  localparam int unsigned WordW     = 64;
  localparam int unsigned FracW     = 53;
  localparam int unsigned FracShift = WordW - FracW;

  // One key injection up front, then five groups of four rounds plus an injection.
  localparam int unsigned NumGroups = 5;
  localparam int unsigned GroupLen  = 5;
  localparam int unsigned NumStages = 1 + NumGroups * GroupLen;

  localparam logic [WordW-1:0] KeyParity = 64'h1BD1_1BDA_A9FC_1A22;

  localparam int unsigned RotAmount [8] = '{16, 42, 12, 31, 16, 32, 24, 21};

  typedef struct packed {
    logic [WordW-1:0] counter_first;
    logic [WordW-1:0] counter_second;
    logic [WordW-1:0] key_first;
    logic [WordW-1:0] key_second;
    logic             last_in;
  } in_beat_t;

  typedef struct packed {
    logic [FracW-1:0] fraction_first;
    logic [FracW-1:0] fraction_second;
    logic             last_out;
  } out_beat_t;

  // State of one lane inside the pipeline: both words and the full key schedule.
  typedef struct packed {
    logic [WordW-1:0] w0;
    logic [WordW-1:0] w1;
    logic [WordW-1:0] k0;
    logic [WordW-1:0] k1;
    logic [WordW-1:0] k2;
    logic             last;
  } lane_t;

  function automatic logic [WordW-1:0] sel_key(input lane_t l, input int unsigned idx);
    logic [WordW-1:0] k;
    unique case (idx)
      0:       k = l.k0;
      1:       k = l.k1;
      default: k = l.k2;
    endcase
    return k;
  endfunction

  // One mix round with a fixed rotation.
  function automatic lane_t mix(input lane_t l, input int unsigned rot);
    lane_t            r;
    logic [WordW-1:0] sum;
    logic [WordW-1:0] rl;
    r   = l;
    sum = l.w0 + l.w1;
    rl  = (l.w1 << rot) | (l.w1 >> (WordW - rot));
    r.w0 = sum;
    r.w1 = rl ^ sum;
    return r;
  endfunction

  // Key injection number inj; the injection before the first round is number zero.
  function automatic lane_t inject(input lane_t l, input int unsigned inj);
    lane_t r;
    r    = l;
    r.w0 = l.w0 + sel_key(l, inj % 3);
    r.w1 = l.w1 + sel_key(l, (inj + 1) % 3) + WordW'(inj);
    return r;
  endfunction

endpackage

### hdl/cbrtf_core.sv
// Threefry pipeline core: one register stage per round or key injection,
// with a valid bit per stage and bubble-collapsing stall logic.
// Depends on cbrtf_pkg.
module cbrtf_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  cbrtf_pkg::lane_t  in_lane_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output cbrtf_pkg::lane_t  out_lane_o
);

  localparam int unsigned N = cbrtf_pkg::NumStages;

  cbrtf_pkg::lane_t stage_q [N];
  cbrtf_pkg::lane_t src     [N];
  cbrtf_pkg::lane_t res     [N];
  logic [N-1:0]     vld_q;
  logic [N-1:0]     vld_d;
  logic [N-1:0]     en;

  // A stage loads when it is empty or when the stage after it loads.
  assign en[N-1] = !vld_q[N-1] || !out_stall_i;

  for (genvar k = 0; k < N - 1; k++) begin : g_en
    assign en[k] = !vld_q[k] || en[k+1];
  end

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam int unsigned J      = (k == 0) ? 0 : k - 1;
    localparam int unsigned Grp    = J / cbrtf_pkg::GroupLen;
    localparam int unsigned Pos    = J % cbrtf_pkg::GroupLen;
    localparam bit          IsInj  = (k == 0) || (Pos == cbrtf_pkg::GroupLen - 1);
    localparam int unsigned InjIdx = (k == 0) ? 0 : Grp + 1;
    localparam int unsigned RotIdx = ((Grp % 2) * 4 + Pos) % 8;
    localparam int unsigned Rot    = cbrtf_pkg::RotAmount[RotIdx];

    if (k == 0) begin : g_first
      assign src[k] = in_lane_i;
    end else begin : g_next
      assign src[k] = stage_q[k-1];
    end

    if (IsInj) begin : g_inj
      assign res[k] = cbrtf_pkg::inject(src[k], InjIdx);
    end else begin : g_mix
      assign res[k] = cbrtf_pkg::mix(src[k], Rot);
    end
  end

  assign vld_d = (en & {vld_q[N-2:0], in_valid_i}) | (~en & vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < N; k++) begin
      if (en[k]) begin
        stage_q[k] <= res[k];
      end
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = vld_q[N-1];
  assign out_lane_o  = stage_q[N-1];

endmodule

### hdl/counter_based_random_threefry_top.sv
// Top level of the Threefry-2x64 20-round counter-based random generator.
// Forms the key schedule, feeds the pipeline core and formats the fractions.
// Depends on cbrtf_pkg and cbrtf_core.
//
// Usage: the input channel (in_valid_i, in_stall_o, in_data_i) takes one
// counter lane per beat: two counter words, two key words and a last marker.
// The output channel (out_valid_o, out_stall_i, out_data_o) returns one beat
// per input beat, in order: the top 53 bits of each result word as unsigned
// fractions of 2^53, and the last marker unchanged.
// An accepted input beat reaches the output beat through one register stage
// for the first key injection and one for each of the 20 rounds and 5 later
// injections. Throughput is one beat per cycle while the receiver does not stall.
// Reset clears every stage valid bit; the block then accepts at once.
// When the receiver stalls, the final stage holds its beat and earlier
// stages keep filling any empty slots; in_stall_o rises only once every
// stage holds a beat.
module counter_based_random_threefry_top (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  cbrtf_pkg::in_beat_t   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output cbrtf_pkg::out_beat_t  out_data_o
);

  cbrtf_pkg::lane_t in_lane;
  cbrtf_pkg::lane_t out_lane;

  always_comb begin
    in_lane.w0   = in_data_i.counter_first;
    in_lane.w1   = in_data_i.counter_second;
    in_lane.k0   = in_data_i.key_first;
    in_lane.k1   = in_data_i.key_second;
    in_lane.k2   = cbrtf_pkg::KeyParity ^ in_data_i.key_first ^ in_data_i.key_second;
    in_lane.last = in_data_i.last_in;
  end

  cbrtf_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_lane_i   (in_lane),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_lane_o  (out_lane)
  );

  always_comb begin
    out_data_o.fraction_first  = out_lane.w0[cbrtf_pkg::WordW-1:cbrtf_pkg::FracShift];
    out_data_o.fraction_second = out_lane.w1[cbrtf_pkg::WordW-1:cbrtf_pkg::FracShift];
    out_data_o.last_out        = out_lane.last;
  end

endmodule

### hdl/cbrtf_checker.sv
// Port-level checks for the Threefry generator top level, and the bind
// that attaches them. Depends on cbrtf_pkg and the top level.
module cbrtf_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input cbrtf_pkg::out_beat_t  out_data_o
);

  // The input side backs up only behind a blocked output beat.
  a_stall_needs_blocked_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while output was not blocked");

  // A full pipeline cannot lose its output beat in the following cycle.
  a_full_keeps_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> out_valid_o)
    else $error("output beat vanished after pipeline was full");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled output beat changed or dropped");

  a_out_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(!out_stall_i))
    else $error("output valid fell without a completed beat");

endmodule

bind counter_based_random_threefry_top cbrtf_checker u_cbrtf_checker (.*);

### sim/tb_counter_based_random_threefry_top.sv
// Testbench for the Threefry-2x64 20-round random generator top level.
// Drives counter lanes through the valid/stall channels and checks each result beat
// against an in-bench prediction. Depends on cbrtf_pkg and the top level.
`timescale 1ns / 1ps

module tb_counter_based_random_threefry_top;

  localparam int unsigned LatencyCycles = 26;
  localparam logic [63:0] SchedParity = 64'h1BD1_1BDA_A9FC_1A22;
  localparam int unsigned MixRot [8] = '{16, 42, 12, 31, 16, 32, 24, 21};

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  cbrtf_pkg::in_beat_t  in_data_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  cbrtf_pkg::out_beat_t out_data_o;

  cbrtf_pkg::out_beat_t pending_fractions [$];
  int        error_count = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        hold_off_cycles = 0;

  counter_based_random_threefry_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic logic [63:0] rotate_left(input logic [63:0] v, input int unsigned n);
    return (v << n) | (v >> (64 - n));
  endfunction

  // Computes both fractions of one lane: key schedule, first injection, then five
  // groups of four mix rounds, each group closed by a key injection.
  function automatic cbrtf_pkg::out_beat_t threefry_fractions(
      input cbrtf_pkg::in_beat_t lane);
    logic [63:0]          sched [3];
    logic [63:0]          x0;
    logic [63:0]          x1;
    cbrtf_pkg::out_beat_t res;
    sched[0] = lane.key_first;
    sched[1] = lane.key_second;
    sched[2] = SchedParity ^ lane.key_first ^ lane.key_second;
    x0 = lane.counter_first + sched[0];
    x1 = lane.counter_second + sched[1];
    for (int g = 1; g <= 5; g++) begin
      for (int rd = 0; rd < 4; rd++) begin
        x0 = x0 + x1;
        x1 = rotate_left(x1, MixRot[((g - 1) % 2) * 4 + rd]) ^ x0;
      end
      x0 = x0 + sched[g % 3];
      x1 = x1 + sched[(g + 1) % 3] + 64'(g);
    end
    res.fraction_first  = x0[63:11];
    res.fraction_second = x1[63:11];
    res.last_out        = lane.last_in;
    return res;
  endfunction

  // Mostly uniform words, with the two extremes mixed in now and then.
  function automatic logic [63:0] random_word();
    logic [63:0] w;
    case ($urandom_range(15))
      0:       w = '0;
      1:       w = '1;
      default: w = {$urandom, $urandom};
    endcase
    return w;
  endfunction

  // Receiver: a requested hold-off wins over the random stalls.
  always @(negedge clk_i) begin
    if (hold_off_cycles > 0) begin
      out_stall_i = 1'b1;
      hold_off_cycles = hold_off_cycles - 1;
    end else begin
      out_stall_i = ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin : check_results
    cbrtf_pkg::out_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_fractions.size() == 0) begin
        $error("result beat with nothing expected: %h", out_data_o);
        error_count++;
      end else begin
        want = pending_fractions.pop_front();
        if (out_data_o.fraction_first !== want.fraction_first) begin
          $error("fraction_first: expected %h, got %h",
                 want.fraction_first, out_data_o.fraction_first);
          error_count++;
        end
        if (out_data_o.fraction_second !== want.fraction_second) begin
          $error("fraction_second: expected %h, got %h",
                 want.fraction_second, out_data_o.fraction_second);
          error_count++;
        end
        if (out_data_o.last_out !== want.last_out) begin
          $error("last_out: expected %b, got %b", want.last_out, out_data_o.last_out);
          error_count++;
        end
      end
    end
  end

  // Entered and left at a falling edge; the beat is expected once it is accepted.
  task automatic send_lane(input cbrtf_pkg::in_beat_t lane);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i  = lane;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_fractions.push_back(threefry_fractions(lane));
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic send_words(input logic [63:0] c0, input logic [63:0] c1,
                            input logic [63:0] k0, input logic [63:0] k1,
                            input logic last);
    cbrtf_pkg::in_beat_t lane;
    lane.counter_first  = c0;
    lane.counter_second = c1;
    lane.key_first      = k0;
    lane.key_second     = k1;
    lane.last_in        = last;
    send_lane(lane);
  endtask

  task automatic wait_for_drain();
    while (pending_fractions.size() != 0) @(negedge clk_i);
    repeat (LatencyCycles + 4) @(negedge clk_i);
  endtask

  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_words('0, '0, '0, '0, 1'b0);
    send_words('0, '0, '0, '0, 1'b1);
    send_words('1, '1, '1, '1, 1'b1);
    send_words('1, '1, '0, '0, 1'b0);
    send_words('0, '0, '1, '1, 1'b0);
    // Keys chosen so that the third schedule word comes out zero.
    send_words('0, '0, SchedParity, '0, 1'b0);
    send_words(64'h8000_0000_0000_0000, '0, '0, '0, 1'b1);
    send_words('0, 64'd1, '0, '0, 1'b0);
    // Additions that wrap around 2^64 right at the first injection.
    send_words('1, 64'd1, 64'd1, '1, 1'b0);
    send_words(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
               64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b1);
    send_words(64'h7FF, 64'h7FF, 64'h7FF, 64'h7FF, 1'b0);
    send_words(64'hFFFF_FFFF_FFFF_F800, '0, '1, '0, 1'b1);
    // Neighboring counters under one key must stay independent lanes.
    for (int i = 0; i < 4; i++) begin
      send_words(64'(i), '0, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
                 1'(i == 3));
    end
    wait_for_drain();
  endtask

  task automatic test_random_phase(input int count, input int idle_pct, input int stall_pct);
    cbrtf_pkg::in_beat_t lane;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) begin
      lane.counter_first  = random_word();
      lane.counter_second = random_word();
      lane.key_first      = random_word();
      lane.key_second     = random_word();
      lane.last_in        = 1'($urandom_range(1));
      send_lane(lane);
    end
    // The sender pauses until every result is back.
    wait_for_drain();
  endtask

  // The receiver holds off long enough that every stage fills and the input stalls.
  task automatic test_backpressure();
    cbrtf_pkg::in_beat_t lane;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_cycles = 4 * LatencyCycles + 50;
    for (int i = 0; i < 80; i++) begin
      lane.counter_first  = 64'(i);
      lane.counter_second = random_word();
      lane.key_first      = random_word();
      lane.key_second     = random_word();
      lane.last_in        = (i % 8 == 7);
      send_lane(lane);
    end
    wait_for_drain();
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random_phase(300, 0, 0);
    test_random_phase(300, 58, 0);
    test_backpressure();
    test_random_phase(300, 0, 58);
    test_random_phase(300, 19, 19);
    repeat (LatencyCycles + 10) @(posedge clk_i);
    if (pending_fractions.size() != 0) begin
      $error("%0d expected result beats never arrived", pending_fractions.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
